FILE: rtl/evsd_pkg.sv
// Shared types, constants and helper functions of the video sample digitizer.
package evsd_pkg;

   localparam int MEDIAN_TAPS = 5;
   localparam int X_BITS      = 10;
   localparam int Y_BITS      = 9;

   localparam int SAMPLE_BITS = 8;
   localparam int COLOR_BITS  = 6;
   localparam int LEVEL_BITS  = 8;
   localparam int FRAME_BITS  = 16;
   localparam int RUN_BITS    = 8;
   localparam int RATE_BITS   = 27;
   localparam int PHASE_BITS  = 25;
   localparam int MINLINE_BITS = 10;
   localparam int WIDTH_BITS  = 10;
   localparam int HEIGHT_BITS = 9;
   localparam int ACC_BITS    = 32;

   localparam int XC_BITS = (X_BITS > MINLINE_BITS) ? X_BITS : MINLINE_BITS;
   localparam int XW_BITS = (X_BITS > WIDTH_BITS) ? X_BITS : WIDTH_BITS;
   localparam int YC_BITS = (Y_BITS > HEIGHT_BITS) ? Y_BITS : HEIGHT_BITS;
   localparam int CNT_BITS = $clog2(MEDIAN_TAPS + 1);
   localparam int MED_RANK = MEDIAN_TAPS / 2;

   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;

   localparam int VSYNC_BIT = 7;
   localparam int HSYNC_BIT = 6;

   localparam logic [RATE_BITS-1:0]   SAMPLE_RATE_RESET = RATE_BITS'(24000000);
   localparam logic [RATE_BITS-1:0]   PIXEL_RATE_RESET  = RATE_BITS'(7159090);
   localparam logic [RUN_BITS-1:0]    VSYNC_RUN_RESET   = RUN_BITS'(20);
   localparam logic [RUN_BITS-1:0]    HSYNC_RUN_RESET   = RUN_BITS'(30);
   localparam logic [MINLINE_BITS-1:0] MIN_LINE_RESET   = MINLINE_BITS'(208);
   localparam logic [WIDTH_BITS-1:0]  ACTIVE_W_RESET    = WIDTH_BITS'(380);
   localparam logic [HEIGHT_BITS-1:0] ACTIVE_H_RESET    = HEIGHT_BITS'(280);

   typedef enum logic [2:0] {
      REG_SAMPLE_RATE   = 3'd0,
      REG_PIXEL_RATE    = 3'd1,
      REG_PHASE_OFFSET  = 3'd2,
      REG_VSYNC_MIN_RUN = 3'd3,
      REG_HSYNC_MIN_RUN = 3'd4,
      REG_MIN_LINE      = 3'd5,
      REG_ACTIVE_WIDTH  = 3'd6,
      REG_ACTIVE_HEIGHT = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic [RATE_BITS-1:0]          sample_rate;
      logic [RATE_BITS-1:0]          pixel_rate;
      logic signed [PHASE_BITS-1:0]  phase_offset;
      logic [RUN_BITS-1:0]           vsync_min_run;
      logic [RUN_BITS-1:0]           hsync_min_run;
      logic [MINLINE_BITS-1:0]       min_line_pixels;
      logic [WIDTH_BITS-1:0]         active_width;
      logic [HEIGHT_BITS-1:0]        active_height;
   } cfg_type;

   typedef struct packed {
      logic                  pixel_write;
      logic [X_BITS-1:0]     pixel_x;
      logic [Y_BITS-1:0]     pixel_y;
      logic                  frame_start;
      logic [FRAME_BITS-1:0] frame_number;
   } track_result_type;

   typedef logic [COLOR_BITS-1:0] color_window_type [MEDIAN_TAPS];

   // A palette channel level is {hi,lo} times 0x55, which is {hi,lo} repeated.
   function automatic logic [LEVEL_BITS-1:0] palette_level(input logic hi, input logic lo);
      palette_level = {hi, lo, hi, lo, hi, lo, hi, lo};
   endfunction

   // Rank selection: a tap is the median when at most MED_RANK taps are smaller
   // and more than MED_RANK taps are smaller or equal.
   function automatic logic [COLOR_BITS-1:0] median_of(input color_window_type win);
      logic [CNT_BITS-1:0]   n_lt;
      logic [CNT_BITS-1:0]   n_le;
      logic                  found;
      logic [COLOR_BITS-1:0] pick;
      found = 1'b0;
      pick  = '0;
      for (int i = 0; i < MEDIAN_TAPS; i++) begin
         n_lt = '0;
         n_le = '0;
         for (int j = 0; j < MEDIAN_TAPS; j++) begin
            if (win[j] < win[i]) begin
               n_lt = n_lt + CNT_BITS'(1);
            end
            if (win[j] <= win[i]) begin
               n_le = n_le + CNT_BITS'(1);
            end
         end
         if (!found && (n_lt <= CNT_BITS'(MED_RANK)) && (n_le > CNT_BITS'(MED_RANK))) begin
            found = 1'b1;
            pick  = win[i];
         end
      end
      median_of = pick;
   endfunction

endpackage

FILE: rtl/ega_video_sample_digitizer.sv
// Top level of the video sample digitizer: input register, processing and result register.
//
//   channel | direction | handshake              | payload
//   req     | in        | req_valid / req_stall  | req_sample_byte
//   rsp     | out       | rsp_valid / rsp_stall  | pixel, position, colour, frame fields
//   csr     | in/out    | psel, penable, pready  | 8 registers at byte address 4*i
//
// A sample is captured in the input register at the edge that accepts it, and its result,
// if it has one, is loaded into the result register when the sample advances out of the
// input register, which a stalled result can hold off.
// One sample is accepted every cycle while the result side is not stalled; the accumulator
// and position registers are updated for each sample that advances.
// Reset is synchronous and leaves the block ready on the next cycle.
// A stalled result holds the input register, which then stalls the request side.
module ega_video_sample_digitizer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [evsd_pkg::SAMPLE_BITS-1:0]    req_sample_byte,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_pixel_write,
   output logic [evsd_pkg::X_BITS-1:0]         rsp_pixel_x,
   output logic [evsd_pkg::Y_BITS-1:0]         rsp_pixel_y,
   output logic [evsd_pkg::COLOR_BITS-1:0]     rsp_pixel_index,
   output logic [evsd_pkg::LEVEL_BITS-1:0]     rsp_red,
   output logic [evsd_pkg::LEVEL_BITS-1:0]     rsp_green,
   output logic [evsd_pkg::LEVEL_BITS-1:0]     rsp_blue,
   output logic                                rsp_frame_start,
   output logic [evsd_pkg::FRAME_BITS-1:0]     rsp_frame_number,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [evsd_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [evsd_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [evsd_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                                csr_pready
);

   evsd_pkg::cfg_type                cfg;
   evsd_pkg::track_result_type       trk;
   logic [evsd_pkg::COLOR_BITS-1:0]  median_color;
   logic [evsd_pkg::COLOR_BITS-1:0]  out_index;

   logic                             in_valid_ff, in_valid_in;
   logic [evsd_pkg::SAMPLE_BITS-1:0] in_byte_ff, in_byte_in;
   logic                             out_valid_ff, out_valid_in;
   logic                             out_write_ff, out_write_in;
   logic [evsd_pkg::X_BITS-1:0]      out_x_ff, out_x_in;
   logic [evsd_pkg::Y_BITS-1:0]      out_y_ff, out_y_in;
   logic [evsd_pkg::COLOR_BITS-1:0]  out_index_ff, out_index_in;
   logic [evsd_pkg::LEVEL_BITS-1:0]  out_red_ff, out_red_in;
   logic [evsd_pkg::LEVEL_BITS-1:0]  out_green_ff, out_green_in;
   logic [evsd_pkg::LEVEL_BITS-1:0]  out_blue_ff, out_blue_in;
   logic                             out_fstart_ff, out_fstart_in;
   logic [evsd_pkg::FRAME_BITS-1:0]  out_frame_ff, out_frame_in;
   logic                             advance;
   logic                             load_out;

   evsd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   evsd_median u_median (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .new_color    (in_byte_ff[evsd_pkg::COLOR_BITS-1:0]),
      .median_color (median_color)
   );

   evsd_track u_track (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .sample_byte (in_byte_ff),
      .cfg         (cfg),
      .result      (trk)
   );

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign load_out  = advance && (trk.pixel_write || trk.frame_start);
   assign out_index = trk.pixel_write ? median_color : '0;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
         in_byte_in  = req_sample_byte;
      end
   end

   always_comb begin
      out_valid_in  = out_valid_ff && rsp_stall;
      out_write_in  = out_write_ff;
      out_x_in      = out_x_ff;
      out_y_in      = out_y_ff;
      out_index_in  = out_index_ff;
      out_red_in    = out_red_ff;
      out_green_in  = out_green_ff;
      out_blue_in   = out_blue_ff;
      out_fstart_in = out_fstart_ff;
      out_frame_in  = out_frame_ff;
      if (load_out) begin
         out_valid_in  = 1'b1;
         out_write_in  = trk.pixel_write;
         out_x_in      = trk.pixel_x;
         out_y_in      = trk.pixel_y;
         out_index_in  = out_index;
         out_red_in    = evsd_pkg::palette_level(out_index[2], out_index[3]);
         out_green_in  = evsd_pkg::palette_level(out_index[1], out_index[3]);
         out_blue_in   = evsd_pkg::palette_level(out_index[0], out_index[3]);
         out_fstart_in = trk.frame_start;
         out_frame_in  = trk.frame_number;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff    <= in_byte_in;
      out_write_ff  <= out_write_in;
      out_x_ff      <= out_x_in;
      out_y_ff      <= out_y_in;
      out_index_ff  <= out_index_in;
      out_red_ff    <= out_red_in;
      out_green_ff  <= out_green_in;
      out_blue_ff   <= out_blue_in;
      out_fstart_ff <= out_fstart_in;
      out_frame_ff  <= out_frame_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_pixel_write  = out_write_ff;
   assign rsp_pixel_x      = out_x_ff;
   assign rsp_pixel_y      = out_y_ff;
   assign rsp_pixel_index  = out_index_ff;
   assign rsp_red          = out_red_ff;
   assign rsp_green        = out_green_ff;
   assign rsp_blue         = out_blue_ff;
   assign rsp_frame_start  = out_fstart_ff;
   assign rsp_frame_number = out_frame_ff;

endmodule

FILE: rtl/evsd_csr.sv
// Configuration register file with an APB-style write and read port.
module evsd_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [evsd_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [evsd_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [evsd_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                                csr_pready,
   output evsd_pkg::cfg_type                   cfg
);

   evsd_pkg::cfg_type       cfg_ff;
   evsd_pkg::cfg_type       cfg_in;
   evsd_pkg::reg_index_type reg_sel;
   logic                    wr_en;

   assign csr_pready = 1'b1;
   assign reg_sel    = evsd_pkg::reg_index_type'(csr_paddr[4:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_sel)
            evsd_pkg::REG_SAMPLE_RATE: begin
               cfg_in.sample_rate = csr_pwdata[evsd_pkg::RATE_BITS-1:0];
            end
            evsd_pkg::REG_PIXEL_RATE: begin
               cfg_in.pixel_rate = csr_pwdata[evsd_pkg::RATE_BITS-1:0];
            end
            evsd_pkg::REG_PHASE_OFFSET: begin
               cfg_in.phase_offset = csr_pwdata[evsd_pkg::PHASE_BITS-1:0];
            end
            evsd_pkg::REG_VSYNC_MIN_RUN: begin
               cfg_in.vsync_min_run = csr_pwdata[evsd_pkg::RUN_BITS-1:0];
            end
            evsd_pkg::REG_HSYNC_MIN_RUN: begin
               cfg_in.hsync_min_run = csr_pwdata[evsd_pkg::RUN_BITS-1:0];
            end
            evsd_pkg::REG_MIN_LINE: begin
               cfg_in.min_line_pixels = csr_pwdata[evsd_pkg::MINLINE_BITS-1:0];
            end
            evsd_pkg::REG_ACTIVE_WIDTH: begin
               cfg_in.active_width = csr_pwdata[evsd_pkg::WIDTH_BITS-1:0];
            end
            evsd_pkg::REG_ACTIVE_HEIGHT: begin
               cfg_in.active_height = csr_pwdata[evsd_pkg::HEIGHT_BITS-1:0];
            end
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         evsd_pkg::REG_SAMPLE_RATE: begin
            csr_prdata = evsd_pkg::CSR_DATA_BITS'(cfg_ff.sample_rate);
         end
         evsd_pkg::REG_PIXEL_RATE: begin
            csr_prdata = evsd_pkg::CSR_DATA_BITS'(cfg_ff.pixel_rate);
         end
         evsd_pkg::REG_PHASE_OFFSET: begin
            csr_prdata = evsd_pkg::CSR_DATA_BITS'(unsigned'(cfg_ff.phase_offset));
         end
         evsd_pkg::REG_VSYNC_MIN_RUN: begin
            csr_prdata = evsd_pkg::CSR_DATA_BITS'(cfg_ff.vsync_min_run);
         end
         evsd_pkg::REG_HSYNC_MIN_RUN: begin
            csr_prdata = evsd_pkg::CSR_DATA_BITS'(cfg_ff.hsync_min_run);
         end
         evsd_pkg::REG_MIN_LINE: begin
            csr_prdata = evsd_pkg::CSR_DATA_BITS'(cfg_ff.min_line_pixels);
         end
         evsd_pkg::REG_ACTIVE_WIDTH: begin
            csr_prdata = evsd_pkg::CSR_DATA_BITS'(cfg_ff.active_width);
         end
         evsd_pkg::REG_ACTIVE_HEIGHT: begin
            csr_prdata = evsd_pkg::CSR_DATA_BITS'(cfg_ff.active_height);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sample_rate     <= evsd_pkg::SAMPLE_RATE_RESET;
         cfg_ff.pixel_rate      <= evsd_pkg::PIXEL_RATE_RESET;
         cfg_ff.phase_offset    <= '0;
         cfg_ff.vsync_min_run   <= evsd_pkg::VSYNC_RUN_RESET;
         cfg_ff.hsync_min_run   <= evsd_pkg::HSYNC_RUN_RESET;
         cfg_ff.min_line_pixels <= evsd_pkg::MIN_LINE_RESET;
         cfg_ff.active_width    <= evsd_pkg::ACTIVE_W_RESET;
         cfg_ff.active_height   <= evsd_pkg::ACTIVE_H_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: rtl/evsd_median.sv
// Colour history shift line and median selection over the newest taps.
module evsd_median (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             advance,
   input  logic [evsd_pkg::COLOR_BITS-1:0]  new_color,
   output logic [evsd_pkg::COLOR_BITS-1:0]  median_color
);

   logic [evsd_pkg::COLOR_BITS-1:0] hist_ff [evsd_pkg::MEDIAN_TAPS-1];
   evsd_pkg::color_window_type      window;

   always_comb begin
      window[0] = new_color;
      for (int i = 1; i < evsd_pkg::MEDIAN_TAPS; i++) begin
         window[i] = hist_ff[i-1];
      end
   end

   assign median_color = evsd_pkg::median_of(window);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < evsd_pkg::MEDIAN_TAPS - 1; i++) begin
            hist_ff[i] <= '0;
         end
      end else if (advance) begin
         for (int i = 0; i < evsd_pkg::MEDIAN_TAPS - 1; i++) begin
            hist_ff[i] <= window[i];
         end
      end
   end

endmodule

FILE: rtl/evsd_track.sv
// Sync separation, rate accumulator resampling and pixel position tracking.
module evsd_track (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  logic [evsd_pkg::SAMPLE_BITS-1:0]  sample_byte,
   input  evsd_pkg::cfg_type                 cfg,
   output evsd_pkg::track_result_type        result
);

   localparam logic [evsd_pkg::X_BITS-1:0]   X_MAX = '1;
   localparam logic [evsd_pkg::Y_BITS-1:0]   Y_MAX = '1;
   localparam logic [evsd_pkg::RUN_BITS-1:0] RUN_MAX = '1;

   logic signed [evsd_pkg::ACC_BITS-1:0] acc_ff, acc_in;
   logic [evsd_pkg::X_BITS-1:0]          x_ff, x_in;
   logic [evsd_pkg::Y_BITS-1:0]          y_ff, y_in;
   logic [evsd_pkg::RUN_BITS-1:0]        vrun_ff, vrun_in;
   logic [evsd_pkg::RUN_BITS-1:0]        hrun_ff, hrun_in;
   logic                                 flag_ff, flag_in;
   logic [evsd_pkg::FRAME_BITS-1:0]      frame_ff, frame_in;

   logic [evsd_pkg::RUN_BITS-1:0]        vrun_inc;
   logic [evsd_pkg::RUN_BITS-1:0]        hrun_inc;
   logic [evsd_pkg::Y_BITS-1:0]          y_mid;
   logic [evsd_pkg::X_BITS-1:0]          x_mid;
   logic                                 fstart;
   logic                                 wrote;
   logic signed [evsd_pkg::ACC_BITS-1:0] sample_ext;
   logic signed [evsd_pkg::ACC_BITS-1:0] pixel_ext;
   logic signed [evsd_pkg::ACC_BITS-1:0] phase_ext;

   assign sample_ext = signed'(evsd_pkg::ACC_BITS'(cfg.sample_rate));
   assign pixel_ext  = signed'(evsd_pkg::ACC_BITS'(cfg.pixel_rate));
   assign phase_ext  = evsd_pkg::ACC_BITS'(cfg.phase_offset);
   assign vrun_inc   = (vrun_ff == RUN_MAX) ? vrun_ff : vrun_ff + 1'b1;
   assign hrun_inc   = (hrun_ff == RUN_MAX) ? hrun_ff : hrun_ff + 1'b1;

   always_comb begin
      vrun_in  = vrun_ff;
      flag_in  = flag_ff;
      frame_in = frame_ff;
      y_mid    = y_ff;
      fstart   = 1'b0;
      if (!sample_byte[evsd_pkg::VSYNC_BIT]) begin
         vrun_in = '0;
         flag_in = 1'b0;
      end else begin
         vrun_in = vrun_inc;
         if (vrun_inc > cfg.vsync_min_run) begin
            vrun_in = '0;
            y_mid   = '0;
            if (!flag_ff) begin
               flag_in  = 1'b1;
               frame_in = frame_ff + 1'b1;
               fstart   = 1'b1;
            end
         end
      end

      wrote = 1'b0;
      x_mid = x_ff;
      if (acc_ff < 0) begin
         acc_in = acc_ff + sample_ext;
         wrote  = (evsd_pkg::XW_BITS'(x_ff) < evsd_pkg::XW_BITS'(cfg.active_width))
                  && (evsd_pkg::YC_BITS'(y_mid) < evsd_pkg::YC_BITS'(cfg.active_height));
         x_mid  = (x_ff == X_MAX) ? x_ff : x_ff + 1'b1;
      end else begin
         acc_in = acc_ff - pixel_ext;
      end

      x_in    = x_mid;
      y_in    = y_mid;
      hrun_in = '0;
      if (sample_byte[evsd_pkg::HSYNC_BIT]) begin
         hrun_in = hrun_inc;
         if ((hrun_inc > cfg.hsync_min_run)
             && (evsd_pkg::XC_BITS'(x_mid) > evsd_pkg::XC_BITS'(cfg.min_line_pixels))) begin
            y_in   = (y_mid == Y_MAX) ? y_mid : y_mid + 1'b1;
            acc_in = sample_ext + phase_ext;
            x_in   = '0;
         end
      end
   end

   always_comb begin
      result.pixel_write  = wrote;
      result.pixel_x      = wrote ? x_ff : '0;
      result.pixel_y      = wrote ? y_mid : '0;
      result.frame_start  = fstart;
      result.frame_number = frame_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= signed'(evsd_pkg::ACC_BITS'(evsd_pkg::SAMPLE_RATE_RESET));
         x_ff     <= '0;
         y_ff     <= '0;
         vrun_ff  <= '0;
         hrun_ff  <= '0;
         flag_ff  <= 1'b0;
         frame_ff <= '0;
      end else if (advance) begin
         acc_ff   <= acc_in;
         x_ff     <= x_in;
         y_ff     <= y_in;
         vrun_ff  <= vrun_in;
         hrun_ff  <= hrun_in;
         flag_ff  <= flag_in;
         frame_ff <= frame_in;
      end
   end

endmodule

FILE: rtl/evsd_checker.sv
// Port-level checker for the video sample digitizer and its bind to the top level.
module evsd_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic                               rsp_pixel_write,
   input logic [evsd_pkg::X_BITS-1:0]        rsp_pixel_x,
   input logic [evsd_pkg::COLOR_BITS-1:0]    rsp_pixel_index,
   input logic [evsd_pkg::LEVEL_BITS-1:0]    rsp_red,
   input logic [evsd_pkg::LEVEL_BITS-1:0]    rsp_green,
   input logic [evsd_pkg::LEVEL_BITS-1:0]    rsp_blue,
   input logic                               rsp_frame_start
);

   // A stalled result transaction stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result transaction dropped while stalled");

   // A stalled result transaction keeps its pixel x position and colour index.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_pixel_x) && $stable(rsp_pixel_index))
      else $error("result payload changed while stalled");

   // Every result transaction carries a pixel or a frame start.
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_pixel_write || rsp_frame_start)
      else $error("result transaction without pixel or frame start");

   // Without a pixel the colour fields are zero.
   a_rsp_blank: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_pixel_write |-> rsp_pixel_index == '0 && rsp_red == '0
         && rsp_green == '0 && rsp_blue == '0)
      else $error("colour fields set on a result without a pixel");

   // The palette levels follow the colour index.
   a_rsp_palette: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pixel_write |->
         rsp_red == evsd_pkg::palette_level(rsp_pixel_index[2], rsp_pixel_index[3])
         && rsp_green == evsd_pkg::palette_level(rsp_pixel_index[1], rsp_pixel_index[3])
         && rsp_blue == evsd_pkg::palette_level(rsp_pixel_index[0], rsp_pixel_index[3]))
      else $error("palette levels do not match the colour index");

endmodule

bind ega_video_sample_digitizer evsd_checker u_evsd_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_pixel_write (rsp_pixel_write),
   .rsp_pixel_x     (rsp_pixel_x),
   .rsp_pixel_index (rsp_pixel_index),
   .rsp_red         (rsp_red),
   .rsp_green       (rsp_green),
   .rsp_blue        (rsp_blue),
   .rsp_frame_start (rsp_frame_start)
);
